[rtl/core/mwlfo_pkg.sv]
// shared types, constants and the sine table builder for the multi-waveform lfo
`default_nettype none

package mwlfo_pkg;

   localparam int DEFAULT_PHASE_BITS      = 32;
   localparam int DEFAULT_SINE_TABLE_BITS = 10;
   localparam int DEFAULT_SAMPLE_BITS     = 16;

   localparam int SAMPLE_MAX_BITS = 24;
   localparam int TARGET_BITS     = 31;
   localparam int FRAC_BITS       = 16;
   localparam int INC_BITS        = 48;
   localparam int LEFT_BITS       = 16;
   localparam int SHIFT_BITS      = 4;
   localparam int SEED_BITS       = 32;
   localparam int CSR_INDEX_BITS  = 2;
   localparam int CSR_DATA_BITS   = 32;

   localparam logic [CSR_INDEX_BITS-1:0] CSR_WAVEFORM   = 2'd0;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_RAMP_SHIFT = 2'd1;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_NOISE_SEED = 2'd2;

   localparam logic [SHIFT_BITS-1:0] RAMP_SHIFT_RESET = 4'd10;
   localparam logic [SEED_BITS-1:0]  LFSR_RESET       = 32'd1;
   localparam logic [SEED_BITS-1:0]  LFSR_TOGGLE      = 32'hA300_0000;
   localparam logic [63:0]           PI_HALF_Q30      = 64'd1686629713;

   typedef enum logic [2:0] {
      WAVE_SINE     = 3'd0,
      WAVE_TRIANGLE = 3'd1,
      WAVE_SAW_UP   = 3'd2,
      WAVE_SAW_DOWN = 3'd3,
      WAVE_SQUARE   = 3'd4,
      WAVE_HOLD     = 3'd5
   } wave_type;

   typedef struct packed {
      logic                 advance;
      wave_type             waveform;
      logic                 seed_load;
      logic [SEED_BITS-1:0] seed;
   } wave_ctrl_type;

   // quarter-wave entry: q30 taylor series through x^15, each term truncated
   function automatic logic [SAMPLE_MAX_BITS-1:0] sine_entry(input int unsigned k,
                                                             input int unsigned tbits,
                                                             input int unsigned sbits);
      logic [63:0] x;
      logic [63:0] x2;
      logic [63:0] term;
      logic [63:0] sum;
      logic [63:0] fs;
      logic [63:0] v;
      x    = (PI_HALF_Q30 * 64'(k)) >> tbits;
      x2   = (x * x) >> 30;
      term = x;
      sum  = x;
      term = ((term * x2) >> 30) / 64'd6;
      sum  = sum - term;
      term = ((term * x2) >> 30) / 64'd20;
      sum  = sum + term;
      term = ((term * x2) >> 30) / 64'd42;
      sum  = sum - term;
      term = ((term * x2) >> 30) / 64'd72;
      sum  = sum + term;
      term = ((term * x2) >> 30) / 64'd110;
      sum  = sum - term;
      term = ((term * x2) >> 30) / 64'd156;
      sum  = sum + term;
      term = ((term * x2) >> 30) / 64'd210;
      sum  = sum - term;
      fs   = 64'd1 << (sbits - 1);
      v    = (sum * fs + (64'd1 << 29)) >> 30;
      if (v > fs - 64'd1) begin
         v = fs - 64'd1;
      end
      return v[SAMPLE_MAX_BITS-1:0];
   endfunction

endpackage

`default_nettype wire

[rtl/core/multi_waveform_lfo_core.sv]
// multi-waveform lfo top level: handshakes, configuration registers, stage control
`default_nettype none

// One sample per req_ transfer, one item per clock cycle sustained while rsp_stall is low. A
// request taken on req_ is registered first in the ramp stage, which holds the ramped phase
// increment, and then in the output stage, which holds the sample, the wrap flag and the
// registered sine rom read. The rate is set by two loops, the 48-bit increment ramp and the
// phase accumulator, each closing within a single stage. The csr_ port is always ready; write
// it only while no request is outstanding. Index 0 selects the waveform (sine, triangle,
// saw up, saw down, square, sample-and-hold; other codes give zero), index 1 the ramp
// length as a power of two, index 2 loads the noise lfsr (zero loads one).

module multi_waveform_lfo_core import mwlfo_pkg::*; #(
   parameter int PHASE_BITS      = DEFAULT_PHASE_BITS,
   parameter int SINE_TABLE_BITS = DEFAULT_SINE_TABLE_BITS,
   parameter int SAMPLE_BITS     = DEFAULT_SAMPLE_BITS
) (
   input  logic                      clock,
   input  logic                      reset,

   input  logic                      req_valid,
   output logic                      req_stall,
   input  logic [TARGET_BITS-1:0]    req_target_increment,

   output logic                      rsp_valid,
   input  logic                      rsp_stall,
   output logic signed [SAMPLE_BITS-1:0] rsp_sample_out,
   output logic                      rsp_cycle_wrapped,

   input  logic                      csr_valid,
   output logic                      csr_ready,
   input  logic [CSR_INDEX_BITS-1:0] csr_index,
   input  logic [CSR_DATA_BITS-1:0]  csr_wdata
);

   wave_type               waveform_ff;
   logic [SHIFT_BITS-1:0]  ramp_shift_ff;
   logic                   ramp_valid_ff, ramp_valid_in;
   logic                   out_valid_ff, out_valid_in;

   logic                   accept;
   logic                   out_free;
   logic                   csr_write;
   logic                   seed_load;
   logic [PHASE_BITS-1:0]  increment;
   logic [SAMPLE_BITS-1:0] sample;
   wave_ctrl_type          wave_ctrl;

   assign csr_ready = 1'b1;
   assign csr_write = csr_valid && csr_ready;

   always_comb begin
      out_free      = !out_valid_ff || !rsp_stall;
      req_stall     = ramp_valid_ff && !out_free;
      accept        = req_valid && !req_stall;
      ramp_valid_in = accept || (ramp_valid_ff && !out_free);
      out_valid_in  = out_free ? ramp_valid_ff : out_valid_ff;
   end

   always_comb begin
      seed_load = 1'b0;
      unique case (csr_index)
         CSR_NOISE_SEED: seed_load = csr_write;
         default:        seed_load = 1'b0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         waveform_ff   <= WAVE_SINE;
         ramp_shift_ff <= RAMP_SHIFT_RESET;
      end else if (csr_write) begin
         unique case (csr_index)
            CSR_WAVEFORM:   waveform_ff   <= wave_type'(csr_wdata[2:0]);
            CSR_RAMP_SHIFT: ramp_shift_ff <= csr_wdata[SHIFT_BITS-1:0];
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         ramp_valid_ff <= 1'b0;
         out_valid_ff  <= 1'b0;
      end else begin
         ramp_valid_ff <= ramp_valid_in;
         out_valid_ff  <= out_valid_in;
      end
   end

   always_comb begin
      wave_ctrl.advance   = ramp_valid_ff && out_free;
      wave_ctrl.waveform  = waveform_ff;
      wave_ctrl.seed_load = seed_load;
      // an all-zero seed would lock the lfsr
      wave_ctrl.seed      = (csr_wdata[SEED_BITS-1:0] == '0) ? LFSR_RESET
                                                             : csr_wdata[SEED_BITS-1:0];
   end

   mwlfo_ramp #(
      .PHASE_BITS (PHASE_BITS)
   ) u_ramp (
      .clock      (clock),
      .reset      (reset),
      .accept     (accept),
      .target     (req_target_increment),
      .ramp_shift (ramp_shift_ff),
      .increment  (increment)
   );

   mwlfo_wave #(
      .PHASE_BITS      (PHASE_BITS),
      .SINE_TABLE_BITS (SINE_TABLE_BITS),
      .SAMPLE_BITS     (SAMPLE_BITS)
   ) u_wave (
      .clock         (clock),
      .reset         (reset),
      .ctrl          (wave_ctrl),
      .increment     (increment),
      .sample_out    (sample),
      .cycle_wrapped (rsp_cycle_wrapped)
   );

   assign rsp_valid      = out_valid_ff;
   assign rsp_sample_out = sample;

endmodule

`default_nettype wire

[rtl/core/mwlfo_ramp.sv]
// phase increment ramp toward the requested target
`default_nettype none

module mwlfo_ramp import mwlfo_pkg::*; #(
   parameter int PHASE_BITS = DEFAULT_PHASE_BITS
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   accept,
   input  logic [TARGET_BITS-1:0] target,
   input  logic [SHIFT_BITS-1:0]  ramp_shift,
   output logic [PHASE_BITS-1:0]  increment
);

   logic [INC_BITS-1:0]    current_ff, current_in;
   logic [INC_BITS-1:0]    step_ff, step_in;
   logic [LEFT_BITS-1:0]   left_ff, left_in;
   logic [TARGET_BITS-1:0] last_target_ff;

   logic [INC_BITS-1:0] target_fx;
   logic [INC_BITS-1:0] diff_up;
   logic [INC_BITS-1:0] diff_dn;
   logic [INC_BITS-1:0] mag;
   logic [INC_BITS-1:0] ramped;
   logic                changed;
   logic                going_up;
   logic                still_ramping;

   always_comb begin
      target_fx = INC_BITS'({target, {FRAC_BITS{1'b0}}});
      changed   = (target != last_target_ff);
      diff_up   = target_fx - current_ff;
      diff_dn   = current_ff - target_fx;
      going_up  = (target_fx >= current_ff);
      mag       = (going_up ? diff_up : diff_dn) >> ramp_shift;

      if (changed) begin
         ramped        = going_up ? current_ff + mag : current_ff - mag;
         step_in       = going_up ? mag : -mag;
         still_ramping = (ramp_shift != '0);
         left_in       = (LEFT_BITS'(1) << ramp_shift) - LEFT_BITS'(1);
      end else begin
         ramped        = current_ff + step_ff;
         step_in       = step_ff;
         still_ramping = (left_ff > LEFT_BITS'(1));
         left_in       = (left_ff == '0) ? '0 : left_ff - LEFT_BITS'(1);
      end

      // last ramp tick lands exactly on the target
      current_in = still_ramping ? ramped : target_fx;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         current_ff     <= '0;
         step_ff        <= '0;
         left_ff        <= '0;
         last_target_ff <= '0;
      end else if (accept) begin
         current_ff     <= current_in;
         step_ff        <= step_in;
         left_ff        <= left_in;
         last_target_ff <= target;
      end
   end

   assign increment = current_ff[INC_BITS-1 -: PHASE_BITS];

endmodule

`default_nettype wire

[rtl/core/mwlfo_wave.sv]
// phase accumulator, waveform generation, sine rom and result register
`default_nettype none

module mwlfo_wave import mwlfo_pkg::*; #(
   parameter int PHASE_BITS      = DEFAULT_PHASE_BITS,
   parameter int SINE_TABLE_BITS = DEFAULT_SINE_TABLE_BITS,
   parameter int SAMPLE_BITS     = DEFAULT_SAMPLE_BITS
) (
   input  logic                   clock,
   input  logic                   reset,
   input  wave_ctrl_type          ctrl,
   input  logic [PHASE_BITS-1:0]  increment,
   output logic [SAMPLE_BITS-1:0] sample_out,
   output logic                   cycle_wrapped
);

   localparam int TAB_N     = 1 << SINE_TABLE_BITS;
   localparam int ADDR_BITS = SINE_TABLE_BITS + 1;
   localparam logic [SAMPLE_BITS-1:0] S_MAX = {1'b0, {(SAMPLE_BITS-1){1'b1}}};
   localparam logic [SAMPLE_BITS-1:0] S_MIN = {1'b1, {(SAMPLE_BITS-1){1'b0}}};
   localparam logic [PHASE_BITS-1:0]  HALF  = {1'b1, {(PHASE_BITS-1){1'b0}}};

   logic [PHASE_BITS-1:0]  phase_ff;
   logic [SAMPLE_BITS-1:0] held_ff, held_in;
   logic                   new_cycle_ff;
   logic [SEED_BITS-1:0]   lfsr_ff, lfsr_in;

   logic [SAMPLE_BITS-1:0] rom_q_ff;
   logic [SAMPLE_BITS-1:0] sample_ff, sample_in;
   logic                   sine_ff;
   logic                   negate_ff;
   logic                   wrap_ff;

   logic [SAMPLE_BITS-1:0] rom_tab [TAB_N+1];

   logic [PHASE_BITS:0]            phase_sum;
   logic [SINE_TABLE_BITS-1:0]     idx;
   logic [ADDR_BITS-1:0]           rom_addr;
   logic [PHASE_BITS-1:0]          tri_dist;
   logic [SAMPLE_BITS:0]           tri_val;
   logic [SAMPLE_BITS-1:0]         saw_val;
   logic [SEED_BITS-1:0]           lfsr_step;

   for (genvar k = 0; k <= TAB_N; k++) begin : g_rom
      assign rom_tab[k] = SAMPLE_BITS'(sine_entry(k, SINE_TABLE_BITS, SAMPLE_BITS));
   end

   always_comb begin
      phase_sum = {1'b0, phase_ff} + {1'b0, increment};

      idx      = phase_ff[PHASE_BITS-3 -: SINE_TABLE_BITS];
      rom_addr = phase_ff[PHASE_BITS-2] ? ADDR_BITS'(TAB_N) - {1'b0, idx} : {1'b0, idx};

      tri_dist = phase_ff[PHASE_BITS-1] ? {1'b0, phase_ff[PHASE_BITS-2:0]} : HALF - phase_ff;
      tri_val  = (SAMPLE_BITS+1)'({tri_dist, {(SAMPLE_BITS+1){1'b0}}} >> PHASE_BITS);
      saw_val  = SAMPLE_BITS'({phase_ff, {SAMPLE_BITS{1'b0}}} >> PHASE_BITS);

      lfsr_step = {1'b0, lfsr_ff[SEED_BITS-1:1]} ^ (lfsr_ff[0] ? LFSR_TOGGLE : '0);
      lfsr_in   = lfsr_ff;
      held_in   = held_ff;

      case (ctrl.waveform)
         WAVE_SINE: begin
            sample_in = '0;
         end
         WAVE_TRIANGLE: begin
            sample_in = tri_val[SAMPLE_BITS] ? S_MAX : tri_val[SAMPLE_BITS-1:0] ^ S_MIN;
         end
         WAVE_SAW_UP: begin
            sample_in = saw_val ^ S_MIN;
         end
         WAVE_SAW_DOWN: begin
            // full scale at phase zero saturates
            sample_in = (saw_val == '0) ? S_MAX : S_MIN - saw_val;
         end
         WAVE_SQUARE: begin
            sample_in = (phase_ff[PHASE_BITS-1] && |phase_ff[PHASE_BITS-2:0]) ? S_MAX : S_MIN;
         end
         WAVE_HOLD: begin
            if (new_cycle_ff) begin
               lfsr_in = lfsr_step;
               held_in = lfsr_step[SEED_BITS-1 -: SAMPLE_BITS] ^ S_MIN;
            end
            sample_in = held_in;
         end
         default: begin
            sample_in = '0;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff     <= '0;
         held_ff      <= '0;
         new_cycle_ff <= 1'b1;
         lfsr_ff      <= LFSR_RESET;
      end else if (ctrl.advance) begin
         phase_ff     <= phase_sum[PHASE_BITS-1:0];
         held_ff      <= held_in;
         new_cycle_ff <= phase_sum[PHASE_BITS];
         lfsr_ff      <= lfsr_in;
      end else if (ctrl.seed_load) begin
         lfsr_ff      <= ctrl.seed;
      end
   end

   always_ff @(posedge clock) begin
      if (ctrl.advance) begin
         rom_q_ff  <= rom_tab[rom_addr];
         sample_ff <= sample_in;
         sine_ff   <= (ctrl.waveform == WAVE_SINE);
         negate_ff <= phase_ff[PHASE_BITS-1];
         wrap_ff   <= phase_sum[PHASE_BITS];
      end
   end

   assign sample_out    = sine_ff ? (negate_ff ? -rom_q_ff : rom_q_ff) : sample_ff;
   assign cycle_wrapped = wrap_ff;

endmodule

`default_nettype wire
